// ===== design/vcdm_pkg.sv =====
// Shared types and constants of the vector change dwell monitor.
package vcdm_pkg;

	localparam int COMP_W     = 16;
	localparam int MAG_W      = 16;
	localparam int SQ_W       = 32;
	localparam int ACC_W      = 38;
	localparam int THR_W      = 17;
	localparam int THR_SQ_W   = 34;
	localparam int WIN_W      = 16;
	localparam int VLEN_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int RES_DEPTH  = 8;
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METRIC_MODE    = 3'd0,
		REG_CONDITION_MODE = 3'd1,
		REG_THRESHOLD      = 3'd2,
		REG_WINDOW_LENGTH  = 3'd3,
		REG_VECTOR_LENGTH  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic step_passed;
		logic fulfilled;
	} result_t;

endpackage

// ===== design/vector_change_dwell_monitor_top.sv =====
// Top level of the vector change dwell monitor.
//
//   Channel   Direction  Payload
//   s_*       in         tdata[15:0] component (signed)
//   m_*       out        tdata[0] fulfilled, tdata[1] step_passed
//   cfg_*     in         cfg_index selects the register, cfg_data carries the value
//
// One component is taken every cycle while s_tready is high. After its last component is
// taken, a vector passes the previous-value read, difference, square, fold and threshold
// test, then the result queue, before its result is offered on m_tvalid. After reset the
// previous vector reads as zero through per-entry valid bits, so no clearing pass is needed.
// s_tready falls only when the eight-entry result queue plus the pipeline items would fill it.
module vector_change_dwell_monitor_top #(
	parameter int MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] component
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] fulfilled, [1] step_passed, [7:2] zero
	input  logic        cfg_we,
	input  logic [vcdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcdm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEN_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = ((LEN_W > vcdm_pkg::VLEN_W) ? LEN_W : vcdm_pkg::VLEN_W) + 1;
	localparam int OCC_W = vcdm_pkg::RES_CNT_W + 1;

	logic                              metric_mode_q;
	logic                              condition_mode_q;
	logic [vcdm_pkg::THR_W-1:0]        threshold_q;
	logic [vcdm_pkg::WIN_W-1:0]        window_length_q;
	logic [vcdm_pkg::VLEN_W-1:0]       vector_length_q;
	logic [vcdm_pkg::THR_SQ_W-1:0]     thr_sq_q;

	logic [IDX_W-1:0]                  comp_idx_q;
	logic [MAX_DIM-1:0]                prev_valid_q;
	logic [vcdm_pkg::ACC_W-1:0]        acc_q;
	logic [vcdm_pkg::WIN_W-1:0]        dwell_q;

	logic                              accept;
	logic [CNT_W-1:0]                  vlen_ext;
	logic [CNT_W-1:0]                  len_c;
	logic [CNT_W-1:0]                  idx_next_c;
	logic                              last_c;

	logic                              valid_s1;
	logic signed [vcdm_pkg::COMP_W-1:0] sample_s1;
	logic                              pvalid_s1;
	logic                              metric_s1;
	logic                              last_s1;
	logic [vcdm_pkg::COMP_W-1:0]       ram_rdata;

	logic signed [vcdm_pkg::COMP_W-1:0] prev_c;
	logic signed [vcdm_pkg::COMP_W:0]   diff_c;
	logic signed [vcdm_pkg::COMP_W:0]   neg_diff_c;
	logic [vcdm_pkg::MAG_W-1:0]        mag_c;

	logic                              valid_s2;
	logic [vcdm_pkg::MAG_W-1:0]        mag_s2;
	logic                              metric_s2;
	logic                              last_s2;
	logic [vcdm_pkg::SQ_W-1:0]         sq_c;

	logic                              valid_s3;
	logic [vcdm_pkg::MAG_W-1:0]        mag_s3;
	logic [vcdm_pkg::SQ_W-1:0]         sq_s3;
	logic                              metric_s3;
	logic                              last_s3;
	logic [vcdm_pkg::ACC_W-1:0]        acc_c;

	logic                              valid_s4;
	logic [vcdm_pkg::ACC_W-1:0]        dist_s4;
	logic [vcdm_pkg::ACC_W-1:0]        limit_c;
	logic                              pass_c;
	logic [vcdm_pkg::WIN_W-1:0]        dwell_c;
	vcdm_pkg::result_t                 result_c;

	logic                              res_valid;
	vcdm_pkg::result_t                 res_data;
	logic [vcdm_pkg::RES_CNT_W-1:0]    res_count;
	logic [OCC_W-1:0]                  occupancy_c;

	// Every item in flight may still produce a result, so it holds a queue slot.
	assign occupancy_c = OCC_W'(res_count) + OCC_W'(valid_s1) + OCC_W'(valid_s2)
		+ OCC_W'(valid_s3) + OCC_W'(valid_s4);
	assign s_tready = (occupancy_c < OCC_W'(vcdm_pkg::RES_DEPTH));
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		vlen_ext = CNT_W'(vector_length_q);
		if (vlen_ext == '0) begin
			len_c = CNT_W'(1);
		end else if (vlen_ext > CNT_W'(MAX_DIM)) begin
			len_c = CNT_W'(MAX_DIM);
		end else begin
			len_c = vlen_ext;
		end
		idx_next_c = CNT_W'(comp_idx_q) + CNT_W'(1);
		last_c     = (idx_next_c >= len_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_mode_q    <= 1'b0;
			condition_mode_q <= 1'b0;
			threshold_q      <= '0;
			window_length_q  <= vcdm_pkg::WIN_W'(1);
			vector_length_q  <= vcdm_pkg::VLEN_W'(8);
			thr_sq_q         <= '0;
		end else begin
			thr_sq_q <= vcdm_pkg::THR_SQ_W'(threshold_q) * vcdm_pkg::THR_SQ_W'(threshold_q);
			if (cfg_we) begin
				unique case (cfg_index)
					vcdm_pkg::REG_METRIC_MODE: begin
						metric_mode_q <= cfg_data[0];
					end
					vcdm_pkg::REG_CONDITION_MODE: begin
						condition_mode_q <= cfg_data[0];
					end
					vcdm_pkg::REG_THRESHOLD: begin
						threshold_q <= cfg_data[vcdm_pkg::THR_W-1:0];
					end
					vcdm_pkg::REG_WINDOW_LENGTH: begin
						window_length_q <= cfg_data[vcdm_pkg::WIN_W-1:0];
					end
					vcdm_pkg::REG_VECTOR_LENGTH: begin
						vector_length_q <= cfg_data[vcdm_pkg::VLEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The RAM returns the old entry on the same-address write, which orders back-to-back
	// accesses to one component without forwarding.
	vcdm_ram #(
		.WIDTH(vcdm_pkg::COMP_W),
		.DEPTH(MAX_DIM)
	) u_prev_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (comp_idx_q),
		.wdata (s_tdata[vcdm_pkg::COMP_W-1:0]),
		.raddr (comp_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_idx_q   <= '0;
			prev_valid_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				prev_valid_q[comp_idx_q] <= 1'b1;
				comp_idx_q <= last_c ? '0 : idx_next_c[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= signed'(s_tdata[vcdm_pkg::COMP_W-1:0]);
			pvalid_s1 <= prev_valid_q[comp_idx_q];
			metric_s1 <= metric_mode_q;
			last_s1   <= last_c;
		end
	end

	always_comb begin
		prev_c     = pvalid_s1 ? signed'(ram_rdata) : '0;
		diff_c     = {sample_s1[vcdm_pkg::COMP_W-1], sample_s1}
			- {prev_c[vcdm_pkg::COMP_W-1], prev_c};
		neg_diff_c = -diff_c;
		mag_c      = diff_c[vcdm_pkg::COMP_W] ? neg_diff_c[vcdm_pkg::MAG_W-1:0]
			: diff_c[vcdm_pkg::MAG_W-1:0];
	end

	assign sq_c = vcdm_pkg::SQ_W'(mag_s2) * vcdm_pkg::SQ_W'(mag_s2);

	always_comb begin
		if (metric_s3) begin
			acc_c = (vcdm_pkg::ACC_W'(mag_s3) > acc_q) ? vcdm_pkg::ACC_W'(mag_s3) : acc_q;
		end else begin
			acc_c = acc_q + vcdm_pkg::ACC_W'(sq_s3);
		end
	end

	always_comb begin
		limit_c = metric_mode_q ? vcdm_pkg::ACC_W'(threshold_q) : vcdm_pkg::ACC_W'(thr_sq_q);
		pass_c  = condition_mode_q ? (dist_s4 > limit_c) : (dist_s4 < limit_c);
		if (!pass_c) begin
			dwell_c = window_length_q;
		end else if (dwell_q != '0) begin
			dwell_c = dwell_q - vcdm_pkg::WIN_W'(1);
		end else begin
			dwell_c = '0;
		end
		result_c.step_passed = pass_c;
		result_c.fulfilled   = pass_c && (dwell_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			acc_q    <= '0;
			dwell_q  <= vcdm_pkg::WIN_W'(1);
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && last_s3;
			if (valid_s3) begin
				acc_q <= last_s3 ? '0 : acc_c;
			end
			if (valid_s4) begin
				dwell_q <= dwell_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s2    <= mag_c;
		metric_s2 <= metric_s1;
		last_s2   <= last_s1;
		mag_s3    <= mag_s2;
		sq_s3     <= sq_c;
		metric_s3 <= metric_s2;
		last_s3   <= last_s2;
		dist_s4   <= acc_c;
	end

	vcdm_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s4),
		.push_data (result_c),
		.pop       (m_tready),
		.out_valid (res_valid),
		.out_data  (res_data),
		.count     (res_count)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {6'b0, res_data.step_passed, res_data.fulfilled};

endmodule

// ===== design/vcdm_ram.sv =====
// Generic single-port-write, registered-read RAM that returns the old data on a same-address write.
module vcdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// ===== design/vcdm_result_fifo.sv =====
// Result queue that decouples the monitor pipeline from the output stream.
module vcdm_result_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  vcdm_pkg::result_t                  push_data,
	input  logic                               pop,
	output logic                               out_valid,
	output vcdm_pkg::result_t                  out_data,
	output logic [vcdm_pkg::RES_CNT_W-1:0]     count
);

	localparam int PTR_W = $clog2(vcdm_pkg::RES_DEPTH);

	vcdm_pkg::result_t     entry_q [vcdm_pkg::RES_DEPTH];
	logic [PTR_W-1:0]      wptr_q;
	logic [PTR_W-1:0]      rptr_q;
	logic [vcdm_pkg::RES_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rptr_q];
	assign count     = count_q;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + vcdm_pkg::RES_CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - vcdm_pkg::RES_CNT_W'(1);
			end
		end
	end

endmodule

// ===== sim/tb_vector_change_dwell_monitor_top.sv =====
// Testbench for the vector change dwell monitor: streamed vectors checked against a predictor.
localparam int VEC_DEPTH = 8;

class dwell_checker;
	logic                               metric;
	logic                               above;
	logic [vcdm_pkg::THR_W-1:0]         thr;
	logic [vcdm_pkg::WIN_W-1:0]         window;
	logic [vcdm_pkg::VLEN_W-1:0]        vlen;
	logic signed [vcdm_pkg::COMP_W-1:0] last_vector [VEC_DEPTH];
	int                                 position;
	logic [vcdm_pkg::ACC_W-1:0]         distance;
	logic [vcdm_pkg::WIN_W-1:0]         dwell;
	vcdm_pkg::result_t                  pending_verdicts [$];
	int                                 error_count;

	function new();
		metric = 1'b0;
		above = 1'b0;
		thr = '0;
		window = 16'd1;
		vlen = 4'd8;
		foreach (last_vector[i])
			last_vector[i] = '0;
		position = 0;
		distance = '0;
		dwell = 16'd1;
		error_count = 0;
	endfunction

	function void write_register(logic [vcdm_pkg::CFG_IDX_W-1:0] index,
			logic [vcdm_pkg::CFG_DATA_W-1:0] value);
		case (index)
			vcdm_pkg::REG_METRIC_MODE: begin
				metric = value[0];
			end
			vcdm_pkg::REG_CONDITION_MODE: begin
				above = value[0];
			end
			vcdm_pkg::REG_THRESHOLD: begin
				thr = value[vcdm_pkg::THR_W-1:0];
			end
			vcdm_pkg::REG_WINDOW_LENGTH: begin
				window = value[vcdm_pkg::WIN_W-1:0];
			end
			vcdm_pkg::REG_VECTOR_LENGTH: begin
				vlen = value[vcdm_pkg::VLEN_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function void take_component(logic [vcdm_pkg::COMP_W-1:0] raw);
		int                         span;
		int                         slot;
		int                         step;
		longint                     mag;
		logic [vcdm_pkg::ACC_W-1:0] limit;
		logic                       pass;
		logic                       done;
		vcdm_pkg::result_t          verdict;
		span = (vlen == 0) ? 1 : ((vlen > VEC_DEPTH) ? VEC_DEPTH : int'(vlen));
		slot = position;
		step = int'($signed(raw)) - int'(last_vector[slot]);
		mag = (step < 0) ? -step : step;
		last_vector[slot] = raw;
		if (!metric)
			distance = distance + vcdm_pkg::ACC_W'(mag * mag);
		else if (mag > distance)
			distance = vcdm_pkg::ACC_W'(mag);
		if (slot + 1 < span) begin
			position = slot + 1;
			return;
		end
		limit = metric ? vcdm_pkg::ACC_W'(thr)
			: vcdm_pkg::ACC_W'(longint'(thr) * longint'(thr));
		pass = above ? (distance > limit) : (distance < limit);
		position = 0;
		distance = '0;
		if (!pass) begin
			dwell = window;
			done = 1'b0;
		end else begin
			if (dwell != 0)
				dwell--;
			done = (dwell == 0);
		end
		verdict.fulfilled = done;
		verdict.step_passed = pass;
		pending_verdicts.push_back(verdict);
	endfunction

	function void check_verdict(logic [7:0] data);
		vcdm_pkg::result_t got;
		vcdm_pkg::result_t want;
		got = vcdm_pkg::result_t'(data[1:0]);
		if (pending_verdicts.size() == 0) begin
			$error("unexpected result %h", data);
			error_count++;
			return;
		end
		want = pending_verdicts.pop_front();
		if (got.fulfilled !== want.fulfilled) begin
			$error("fulfilled: expected %0b, got %0b", want.fulfilled, got.fulfilled);
			error_count++;
		end
		if (got.step_passed !== want.step_passed) begin
			$error("step_passed: expected %0b, got %0b", want.step_passed, got.step_passed);
			error_count++;
		end
	endfunction
endclass

module tb_vector_change_dwell_monitor_top;
	localparam int HALF_PERIOD = 2;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS = 92;
	localparam logic [vcdm_pkg::CFG_IDX_W-1:0] FIRST_FREE_INDEX = 3'd5;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [15:0]                     s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [7:0]                      m_tdata;
	logic                            cfg_we;
	logic [vcdm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [vcdm_pkg::CFG_DATA_W-1:0] cfg_data;

	dwell_checker tracker;
	int           burst_left = 0;
	bit           hold_off_req = 1'b0;
	int           hold_left = 0;
	logic [15:0]  stall_pattern = 16'hFFFF;
	int           stall_phase = 0;

	vector_change_dwell_monitor_top #(
		.MAX_DIM(VEC_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#2000000;
		$display("tb_vector_change_dwell_monitor_top failed");
		$finish;
	end

	function automatic int near(int base, int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	task automatic send_component(input logic [vcdm_pkg::COMP_W-1:0] value);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		tracker.take_component(value);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (tracker.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vcdm_pkg::CFG_IDX_W-1:0] index,
			input logic [vcdm_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		tracker.write_register(index, value);
	endtask

	task automatic close_writes();
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic metric, input logic above,
			input logic [vcdm_pkg::THR_W-1:0] thr, input logic [vcdm_pkg::WIN_W-1:0] win,
			input logic [vcdm_pkg::VLEN_W-1:0] vlen);
		wait_idle();
		write_reg(vcdm_pkg::REG_METRIC_MODE, vcdm_pkg::CFG_DATA_W'(metric));
		write_reg(vcdm_pkg::REG_CONDITION_MODE, vcdm_pkg::CFG_DATA_W'(above));
		write_reg(vcdm_pkg::REG_THRESHOLD, vcdm_pkg::CFG_DATA_W'(thr));
		write_reg(vcdm_pkg::REG_WINDOW_LENGTH, vcdm_pkg::CFG_DATA_W'(win));
		write_reg(vcdm_pkg::REG_VECTOR_LENGTH, vcdm_pkg::CFG_DATA_W'(vlen));
		close_writes();
	endtask

	// The receiver follows a 16-bit stall pattern, redrawn at each pass, and honors long hold-off requests.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tracker.check_verdict(m_tdata);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (stall_phase == 0)
				stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
					: (16'($urandom) | 16'($urandom));
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= stall_pattern[stall_phase];
			end
			stall_phase = (stall_phase + 1) % 16;
		end
	end

	initial begin
		int                          phase;
		int                          sent;
		int                          spread;
		bit                          noisy;
		logic                        metric;
		logic                        above;
		logic [vcdm_pkg::THR_W-1:0]  thr;
		logic [vcdm_pkg::WIN_W-1:0]  win;
		logic [vcdm_pkg::VLEN_W-1:0] vlen;
		logic [vcdm_pkg::COMP_W-1:0] value;

		tracker = new();
		noisy = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Extreme components against the cleared previous vector, default settings.
		send_component(16'h7FFF);
		send_component(16'h8000);
		send_component(16'h0000);
		send_component(16'hFFFF);
		send_component(16'h0001);
		send_component(16'h5555);
		send_component(16'hAAAA);
		send_component(16'h7FFF);

		// Zero vector length acts as one; zero window fulfills on the first pass.
		apply_settings(1'b1, 1'b1, 17'd100, 16'd0, 4'd0);
		send_component(16'h8000);
		send_component(16'h8000);

		// Oversized vector length saturates, then is lowered in the middle of a vector.
		apply_settings(1'b0, 1'b0, 17'h1FFFF, 16'hFFFF, 4'hF);
		send_component(16'h7FFF);
		send_component(16'h8000);
		send_component(16'h0000);
		wait_idle();
		write_reg(vcdm_pkg::REG_VECTOR_LENGTH, vcdm_pkg::CFG_DATA_W'(2));
		close_writes();
		send_component(16'h1234);

		// Metric switched in the middle of a vector, plus a write to a randomly chosen unused index.
		wait_idle();
		write_reg(vcdm_pkg::REG_VECTOR_LENGTH, vcdm_pkg::CFG_DATA_W'(4));
		write_reg(vcdm_pkg::CFG_IDX_W'(FIRST_FREE_INDEX + $urandom_range(0, 2)), '1);
		close_writes();
		send_component(16'h4000);
		send_component(16'hC000);
		wait_idle();
		write_reg(vcdm_pkg::REG_METRIC_MODE, vcdm_pkg::CFG_DATA_W'(1));
		write_reg(vcdm_pkg::REG_THRESHOLD, vcdm_pkg::CFG_DATA_W'(0));
		close_writes();
		send_component(16'h0100);
		send_component(16'hFF00);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 4))
				0: spread = 0;
				1: spread = 3;
				2: spread = 60;
				3: spread = 2000;
				default: spread = 30000;
			endcase
			metric = 1'($urandom_range(0, 1));
			above = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: thr = '0;
				1: thr = '1;
				default: thr = vcdm_pkg::THR_W'($urandom_range(0, 3 * spread + 2));
			endcase
			case ($urandom_range(0, 7))
				0: win = '0;
				1: win = '1;
				default: win = vcdm_pkg::WIN_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 7))
				0: vlen = '0;
				1: vlen = vcdm_pkg::VLEN_W'($urandom_range(9, 15));
				default: vlen = vcdm_pkg::VLEN_W'($urandom_range(1, 8));
			endcase
			apply_settings(metric, above, thr, win, vlen);
			if (phase % 5 == 2)
				hold_off_req = 1'b1;
			for (sent = 0; sent < PHASE_ITEMS; sent++) begin
				if (tracker.position == 0)
					noisy = ($urandom_range(0, 4) == 0);
				if (noisy)
					value = 16'($urandom);
				else
					value = 16'(near(int'(tracker.last_vector[tracker.position]), spread));
				send_component(value);
			end
		end

		wait_idle();
		if (tracker.error_count == 0)
			$display("tb_vector_change_dwell_monitor_top passed");
		else
			$display("tb_vector_change_dwell_monitor_top failed");
		$finish;
	end
endmodule

// ===== vector_change_dwell_monitor_top.f =====
design/vcdm_pkg.sv
design/vcdm_ram.sv
design/vcdm_result_fifo.sv
design/vector_change_dwell_monitor_top.sv
sim/tb_vector_change_dwell_monitor_top.sv
